/* hw/rtl/cfr_pkg.sv */
// Shared types and constants for the control frame receiver.
// Used by every module of the block; depends on nothing.
package cfr_pkg;

    localparam int FRAME_LEN = 20;
    localparam int POS_W     = 5;

    typedef logic [POS_W-1:0] t_pos;

    localparam t_pos POS_SYNC0 = t_pos'(0);
    localparam t_pos POS_SYNC1 = t_pos'(1);
    localparam t_pos POS_LAST  = t_pos'(FRAME_LEN - 1);

    localparam logic [7:0] SYNC0   = 8'd1;
    localparam logic [7:0] SYNC1   = 8'd16;
    localparam logic [8:0] SUM_MOD = 9'd255;

    // Frame byte positions that feed the result
    localparam int B_TOUCH    = 3;
    localparam int B_PITCH    = 4;
    localparam int B_JOG_PLS  = 8;
    localparam int B_JOG_SPD  = 10;
    localparam int B_JOG_FLG  = 12;
    localparam int B_CUE_LOOP = 14;
    localparam int B_PLAY     = 15;
    localparam int B_SEARCH   = 16;
    localparam int B_TEMPO    = 17;
    localparam int B_MODE     = 18;

    localparam int FIRST_USED = B_TOUCH;
    localparam int LAST_USED  = B_MODE;
    localparam int USED_N     = LAST_USED - FIRST_USED + 1;
    localparam int USED_W     = $clog2(USED_N);

    localparam int JOG_ACTIVE_BIT   = 7;
    localparam int JOG_FORWARD_BIT  = 6;
    localparam int JOG_PRESSURE_BIT = 4;

    localparam logic CMD_STORE  = 1'b0;
    localparam logic CMD_COMMIT = 1'b1;

    typedef struct packed {
        logic       kind;
        t_pos       pos;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_xfer;

    typedef struct packed {
        logic [7:0]  touch;
        logic [15:0] pitch;
        logic [15:0] jog_pulse;
        logic [15:0] jog_speed;
        logic [2:0]  jog_flags;
        logic [7:0]  buttons_cue_loop;
        logic [1:0]  buttons_play;
        logic [3:0]  buttons_search;
        logic [6:0]  buttons_tempo;
        logic [5:0]  buttons_mode;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_res_xfer;

endpackage

/* hw/rtl/cfr_front.sv */
// Front end: tracks frame position and mod-255 checksum, classifies each byte.
// Emits store commands and a commit on a good checksum. Depends on cfr_pkg.
module cfr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_q_full,
    output cfr_pkg::t_cmd_xfer o_cmd
);
    import cfr_pkg::*;

    t_pos       r_pos, n_pos;
    logic [7:0] r_sum, n_sum;
    logic       accept;
    logic [8:0] sum_raw;
    logic [8:0] sum_mod;

    assign accept  = i_push && !i_q_full;
    assign sum_raw = {1'b0, r_sum} + {1'b0, i_rx_byte};
    // r_sum <= 254, so one subtract is enough
    assign sum_mod = (sum_raw >= SUM_MOD) ? (sum_raw - SUM_MOD) : sum_raw;

    always_comb begin
        n_pos          = r_pos;
        n_sum          = r_sum;
        o_cmd.valid    = 1'b0;
        o_cmd.cmd.kind = CMD_STORE;
        o_cmd.cmd.pos  = r_pos;
        o_cmd.cmd.data = i_rx_byte;
        if (accept) begin
            if (r_pos == POS_SYNC0 && i_rx_byte != SYNC0) begin
                n_pos = POS_SYNC0;
            end else if (r_pos == POS_SYNC1 && i_rx_byte != SYNC1) begin
                n_pos = POS_SYNC0;
            end else if (r_pos < POS_LAST) begin
                o_cmd.valid = 1'b1;
                n_pos       = r_pos + t_pos'(1);
                n_sum       = (r_pos == POS_SYNC0) ? i_rx_byte : sum_mod[7:0];
            end else begin
                n_pos = POS_SYNC0;
                if (i_rx_byte == r_sum) begin
                    o_cmd.valid    = 1'b1;
                    o_cmd.cmd.kind = CMD_COMMIT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_SYNC0;
            r_sum <= 8'd0;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

endmodule

/* hw/rtl/cfr_cmd_queue.sv */
// Two-entry command queue between front end and back end.
// Depends on cfr_pkg for the command type.
module cfr_cmd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cfr_pkg::t_cmd_xfer i_push,
    input  logic               i_pop,
    output logic               o_full,
    output cfr_pkg::t_cmd_xfer o_head
);
    import cfr_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full       = (r_cnt == 2'd2);
    assign o_head       = {(r_cnt != 2'd0), r_slot[r_rd]};
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

/* hw/rtl/cfr_back.sv */
// Back end: writes frame bytes into the frame registers and, on commit,
// unpacks them into a result transaction. Depends on cfr_pkg.
module cfr_back (
    input  logic               i_clk,
    input  cfr_pkg::t_cmd_xfer i_head,
    input  logic               i_res_full,
    output logic               o_pop,
    output cfr_pkg::t_res_xfer o_res
);
    import cfr_pkg::*;

    logic [7:0]      r_frame [USED_N];
    logic            is_commit;
    logic            in_range;
    t_pos            ofs;
    logic [7:0]      jog;

    assign is_commit   = (i_head.cmd.kind == CMD_COMMIT);
    assign o_pop       = i_head.valid && (!is_commit || !i_res_full);
    assign in_range    = (i_head.cmd.pos >= t_pos'(FIRST_USED))
                      && (i_head.cmd.pos <= t_pos'(LAST_USED));
    assign ofs         = i_head.cmd.pos - t_pos'(FIRST_USED);

    always_ff @(posedge i_clk) begin
        if (o_pop && !is_commit && in_range) begin
            r_frame[ofs[USED_W-1:0]] <= i_head.cmd.data;
        end
    end

    assign jog = r_frame[B_JOG_FLG - FIRST_USED];

    always_comb begin
        o_res.valid                = i_head.valid && is_commit && !i_res_full;
        o_res.res.touch            = r_frame[B_TOUCH - FIRST_USED];
        o_res.res.pitch            = {r_frame[B_PITCH - FIRST_USED],
                                      r_frame[B_PITCH + 1 - FIRST_USED]};
        o_res.res.jog_pulse        = {r_frame[B_JOG_PLS - FIRST_USED],
                                      r_frame[B_JOG_PLS + 1 - FIRST_USED]};
        o_res.res.jog_speed        = {r_frame[B_JOG_SPD - FIRST_USED],
                                      r_frame[B_JOG_SPD + 1 - FIRST_USED]};
        o_res.res.jog_flags        = {jog[JOG_ACTIVE_BIT], jog[JOG_FORWARD_BIT],
                                      jog[JOG_PRESSURE_BIT]};
        o_res.res.buttons_cue_loop = r_frame[B_CUE_LOOP - FIRST_USED];
        o_res.res.buttons_play     = r_frame[B_PLAY - FIRST_USED][1:0];
        o_res.res.buttons_search   = r_frame[B_SEARCH - FIRST_USED][3:0];
        o_res.res.buttons_tempo    = r_frame[B_TEMPO - FIRST_USED][6:0];
        o_res.res.buttons_mode     = r_frame[B_MODE - FIRST_USED][5:0];
    end

endmodule

/* hw/rtl/cfr_result_queue.sv */
// Two-entry result queue that drives the output ports.
// Depends on cfr_pkg for the result type.
module cfr_result_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cfr_pkg::t_res_xfer i_push,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output cfr_pkg::t_result   o_head
);
    import cfr_pkg::*;

    t_result    r_slot [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_slot[r_rd];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_push.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

/* hw/rtl/control_frame_receiver_core.sv */
// Control frame receiver: bytes in through a push/full queue interface,
// decoded frames out through an empty/pop queue interface.
//
// Input: one serial byte per transaction on i_rx_byte, accepted when push is
// high and full is low. One byte per cycle is taken while full stays low; the
// front end updates position and the mod-255 checksum for each accepted byte.
// Frames are 20 bytes: byte 0 = 1, byte 1 = 16, byte 19 = sum of bytes 0..18
// mod 255. Bad sync bytes are dropped and hunting restarts; a frame with a
// bad checksum produces nothing.
// Output: one result transaction per good frame, visible once the commit has
// passed the command queue and the back end has pushed it into the result queue
// (later while the result queue is full), held while empty is low until pop.
// Stall: a two-entry command queue parts front and back end and a two-entry
// result queue parts the back end from the receiver. When the receiver stops
// popping, the result queue fills, the back end holds its commit, the command
// queue fills and full rises; no byte or result is lost.
// Reset (synchronous, i_rst_n low): both queues empty, position 0, sum 0.
// Frame byte registers are not reset; every read byte is written first.
module control_frame_receiver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic [7:0]  i_rx_byte,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_touch,
    output logic [15:0] o_pitch,
    output logic [15:0] o_jog_pulse,
    output logic [15:0] o_jog_speed,
    output logic [2:0]  o_jog_flags,
    output logic [7:0]  o_buttons_cue_loop,
    output logic [1:0]  o_buttons_play,
    output logic [3:0]  o_buttons_search,
    output logic [6:0]  o_buttons_tempo,
    output logic [5:0]  o_buttons_mode
);
    import cfr_pkg::*;

    t_cmd_xfer front_cmd;
    t_cmd_xfer q_head;
    logic      back_pop;
    t_res_xfer back_res;
    logic      res_full;
    t_result   res_head;

    cfr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (full),
        .o_cmd     (front_cmd)
    );

    cfr_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_cmd),
        .i_pop   (back_pop),
        .o_full  (full),
        .o_head  (q_head)
    );

    cfr_back u_back (
        .i_clk      (i_clk),
        .i_head     (q_head),
        .i_res_full (res_full),
        .o_pop      (back_pop),
        .o_res      (back_res)
    );

    cfr_result_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_res),
        .i_pop   (pop),
        .o_full  (res_full),
        .o_empty (empty),
        .o_head  (res_head)
    );

    assign o_touch            = res_head.touch;
    assign o_pitch            = res_head.pitch;
    assign o_jog_pulse        = res_head.jog_pulse;
    assign o_jog_speed        = res_head.jog_speed;
    assign o_jog_flags        = res_head.jog_flags;
    assign o_buttons_cue_loop = res_head.buttons_cue_loop;
    assign o_buttons_play     = res_head.buttons_play;
    assign o_buttons_search   = res_head.buttons_search;
    assign o_buttons_tempo    = res_head.buttons_tempo;
    assign o_buttons_mode     = res_head.buttons_mode;

`ifndef SYNTH
    // A command is only produced for an accepted byte
    a_cmd_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_cmd.valid |-> (push && !full))
        else $error("front end issued a command without an accepted byte");

    // A queued command is visible to the back end on the next cycle
    a_cmd_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_cmd.valid |=> q_head.valid)
        else $error("accepted command not visible in command queue");

    // A popped commit always leaves a result waiting
    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (back_pop && q_head.cmd.kind == CMD_COMMIT) |=> !empty)
        else $error("commit popped but no result queued");

    // Back end never drops a commit: if it cannot push it must not pop it
    a_commit_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_head.valid && q_head.cmd.kind == CMD_COMMIT && res_full) |-> !back_pop)
        else $error("commit popped while result queue full");
`endif

endmodule

/* verif/tb_control_frame_receiver_core.sv */
// Testbench for control_frame_receiver_core: streams sync/checksum framed bytes,
// predicts each decoded frame and checks it against the result queue interface.
// Depends on cfr_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_control_frame_receiver_core;
    import cfr_pkg::*;

    localparam int BYTE_TARGET = 1850;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 20;
    localparam int IDLE_PCT    = 11;

    // receiver timeline, in its own cycles
    localparam int HOLD_START = 1000;
    localparam int HOLD_LEN   = 300;
    localparam int RX_CALM_LO = 1500;
    localparam int RX_CALM_HI = 2000;
    // sender stretch without gaps, in transactions
    localparam int TX_CALM_LO = 300;
    localparam int TX_CALM_HI = 600;

    // Tracks the frame hunt and holds the decoded frames still owed by the core
    class frame_scoreboard;
        t_pos       hunt_pos;
        logic [7:0] frame_sum;
        logic [7:0] frame_bytes [FRAME_LEN];
        t_result    decoded_q [$];
        int         errors;

        function new();
            hunt_pos  = POS_SYNC0;
            frame_sum = 8'd0;
            errors    = 0;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        // Called for every accepted byte transaction
        function void note_byte(input logic [7:0] b);
            logic [8:0] acc;
            t_result    r;
            if (hunt_pos == POS_SYNC0 && b != SYNC0) begin
                return;
            end
            if (hunt_pos == POS_SYNC1 && b != SYNC1) begin
                hunt_pos = POS_SYNC0;
                return;
            end
            if (hunt_pos < POS_LAST) begin
                frame_bytes[hunt_pos] = b;
                acc = (hunt_pos == POS_SYNC0) ? {1'b0, b} : {1'b0, frame_sum} + {1'b0, b};
                if (acc >= SUM_MOD) begin
                    acc = acc - SUM_MOD;
                end
                frame_sum = acc[7:0];
                hunt_pos  = hunt_pos + t_pos'(1);
                return;
            end
            // checksum byte: frame ends here either way
            hunt_pos = POS_SYNC0;
            if (b != frame_sum) begin
                return;
            end
            r.touch            = frame_bytes[B_TOUCH];
            r.pitch            = {frame_bytes[B_PITCH], frame_bytes[B_PITCH+1]};
            r.jog_pulse        = {frame_bytes[B_JOG_PLS], frame_bytes[B_JOG_PLS+1]};
            r.jog_speed        = {frame_bytes[B_JOG_SPD], frame_bytes[B_JOG_SPD+1]};
            r.jog_flags        = {frame_bytes[B_JOG_FLG][JOG_ACTIVE_BIT],
                                  frame_bytes[B_JOG_FLG][JOG_FORWARD_BIT],
                                  frame_bytes[B_JOG_FLG][JOG_PRESSURE_BIT]};
            r.buttons_cue_loop = frame_bytes[B_CUE_LOOP];
            r.buttons_play     = frame_bytes[B_PLAY][1:0];
            r.buttons_search   = frame_bytes[B_SEARCH][3:0];
            r.buttons_tempo    = frame_bytes[B_TEMPO][6:0];
            r.buttons_mode     = frame_bytes[B_MODE][5:0];
            decoded_q.push_back(r);
        endfunction

        task cmp_field(input string name, input logic [15:0] got, input logic [15:0] exp);
            if (got !== exp) begin
                report($sformatf("%s got 0x%0h expected 0x%0h", name, got, exp));
            end
        endtask

        // Called for every accepted result transaction
        task check_result(input t_result got);
            t_result exp;
            if (decoded_q.size() == 0) begin
                report("result popped with no decoded frame outstanding");
                return;
            end
            exp = decoded_q.pop_front();
            cmp_field("touch",            16'(got.touch),            16'(exp.touch));
            cmp_field("pitch",            got.pitch,                 exp.pitch);
            cmp_field("jog_pulse",        got.jog_pulse,             exp.jog_pulse);
            cmp_field("jog_speed",        got.jog_speed,             exp.jog_speed);
            cmp_field("jog_flags",        16'(got.jog_flags),        16'(exp.jog_flags));
            cmp_field("buttons_cue_loop", 16'(got.buttons_cue_loop), 16'(exp.buttons_cue_loop));
            cmp_field("buttons_play",     16'(got.buttons_play),     16'(exp.buttons_play));
            cmp_field("buttons_search",   16'(got.buttons_search),   16'(exp.buttons_search));
            cmp_field("buttons_tempo",    16'(got.buttons_tempo),    16'(exp.buttons_tempo));
            cmp_field("buttons_mode",     16'(got.buttons_mode),     16'(exp.buttons_mode));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        push      = 1'b0;
    logic [7:0]  i_rx_byte = 8'd0;
    logic        pop       = 1'b0;
    logic        full;
    logic        empty;
    logic [7:0]  o_touch;
    logic [15:0] o_pitch;
    logic [15:0] o_jog_pulse;
    logic [15:0] o_jog_speed;
    logic [2:0]  o_jog_flags;
    logic [7:0]  o_buttons_cue_loop;
    logic [1:0]  o_buttons_play;
    logic [3:0]  o_buttons_search;
    logic [6:0]  o_buttons_tempo;
    logic [5:0]  o_buttons_mode;

    frame_scoreboard sb;
    int              bytes_sent  = 0;
    int              cycle_count = 0;

    control_frame_receiver_core u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .i_rx_byte          (i_rx_byte),
        .full               (full),
        .empty              (empty),
        .pop                (pop),
        .o_touch            (o_touch),
        .o_pitch            (o_pitch),
        .o_jog_pulse        (o_jog_pulse),
        .o_jog_speed        (o_jog_speed),
        .o_jog_flags        (o_jog_flags),
        .o_buttons_cue_loop (o_buttons_cue_loop),
        .o_buttons_play     (o_buttons_play),
        .o_buttons_search   (o_buttons_search),
        .o_buttons_tempo    (o_buttons_tempo),
        .o_buttons_mode     (o_buttons_mode)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // One byte transaction; returns at the edge that accepted it
    task send_byte(input logic [7:0] b);
        bit calm;
        calm = (bytes_sent >= TX_CALM_LO && bytes_sent < TX_CALM_HI);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= b;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task send_frame();
        logic [7:0] f [FRAME_LEN];
        logic [8:0] acc;
        int         fill_mode;
        int         kind;
        int         len;
        fill_mode = $urandom_range(9);
        f[0] = SYNC0;
        f[1] = SYNC1;
        acc  = {1'b0, SYNC0} + {1'b0, SYNC1};
        for (int i = 2; i < FRAME_LEN - 1; i++) begin
            case (fill_mode)
                0:       f[i] = 8'h00;
                1:       f[i] = 8'hFF;
                default: f[i] = 8'($urandom_range(255));
            endcase
            acc = acc + {1'b0, f[i]};
            if (acc >= SUM_MOD) acc = acc - SUM_MOD;
        end
        f[FRAME_LEN-1] = acc[7:0];
        len  = FRAME_LEN;
        kind = $urandom_range(99);
        if (kind < 70) begin
            // well formed
        end else if (kind < 80) begin
            f[FRAME_LEN-1] = f[FRAME_LEN-1] ^ 8'($urandom_range(1, 255));
        end else if (kind < 85) begin
            f[FRAME_LEN-1] = 8'hFF;   // can never match the mod-255 sum
        end else if (kind < 95) begin
            len = $urandom_range(2, FRAME_LEN - 1);
        end else begin
            len  = 2;
            f[1] = 8'($urandom_range(255));
            if (f[1] == SYNC1 || $urandom_range(1) == 0) f[1] = SYNC0;
        end
        for (int i = 0; i < len; i++) begin
            send_byte(f[i]);
        end
    endtask

    // Receiver side: checks popped results and randomizes pop
    initial begin
        t_result got;
        int      rx_cycle;
        int      hold_left;
        bit      calm;
        rx_cycle  = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                got.touch            = o_touch;
                got.pitch            = o_pitch;
                got.jog_pulse        = o_jog_pulse;
                got.jog_speed        = o_jog_speed;
                got.jog_flags        = o_jog_flags;
                got.buttons_cue_loop = o_buttons_cue_loop;
                got.buttons_play     = o_buttons_play;
                got.buttons_search   = o_buttons_search;
                got.buttons_tempo    = o_buttons_tempo;
                got.buttons_mode     = o_buttons_mode;
                sb.check_result(got);
            end
            rx_cycle++;
            if (rx_cycle == HOLD_START) hold_left = HOLD_LEN;
            calm = (rx_cycle >= RX_CALM_LO && rx_cycle < RX_CALM_HI);
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bad first byte, both extremes
        send_byte(8'hFF);
        send_byte(8'h00);
        // bad second byte that is itself a sync0: must not restart the hunt
        send_byte(SYNC0);
        send_byte(SYNC0);
        send_byte(SYNC1);   // lands at position 0, dropped
        // good frame with every payload byte at 0xFF; sum works out to 17
        send_byte(SYNC0);
        send_byte(SYNC1);
        for (int i = 2; i < FRAME_LEN - 1; i++) begin
            send_byte(8'hFF);
        end
        send_byte(8'd17);

        while (bytes_sent < BYTE_TARGET) begin
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
            end
            send_frame();
        end
        push <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/cfr_pkg.sv
hw/rtl/cfr_front.sv
hw/rtl/cfr_cmd_queue.sv
hw/rtl/cfr_back.sv
hw/rtl/cfr_result_queue.sv
hw/rtl/control_frame_receiver_core.sv
verif/tb_control_frame_receiver_core.sv
